FILE: rtl/hsg_pkg.sv
// ----------------------------------------------------------------------------
// hsg_pkg: shared types and constants of the hypotrochoid segment generator
// Holds field widths, configuration register indexes, divider handshake
// structs and the elaboration-time builder of the Q1.15 sine table.
// ----------------------------------------------------------------------------
package hsg_pkg;

    localparam int TRIG_FRAC_BITS = 15;
    localparam int COORD_BITS     = 14;
    localparam int STEP_LIMIT     = 36000;
    localparam int NUM_ANGLES     = 360;
    localparam int QUARTER_TURN   = 90;
    localparam int HALF_TURN      = 180;

    localparam int ANGLE_W    = 9;
    localparam int TRIG_W     = TRIG_FRAC_BITS + 1;
    localparam int STEP_W     = 32;
    localparam int CX_W       = 12;
    localparam int R_W        = 11;
    localparam int RIN_W      = 12;
    localparam int D_W        = 10;
    localparam int RR_W       = 13;
    localparam int EXACT_W    = 30;
    localparam int PROD_W     = R_W + STEP_W;
    localparam int DIV_W      = RIN_W;
    localparam int DIV_CNT_W  = $clog2(PROD_W);
    localparam int OUT_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Q2.30 radians per degree
    localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;

    // reciprocals giving exact floor division of a 32-bit value by each
    // taylor divisor (2k)(2k+1)
    localparam int          RECIP_SHIFT    = 40;
    localparam logic [63:0] TAYLOR_RECIP_1 = ((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6;
    localparam logic [63:0] TAYLOR_RECIP_2 = ((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20;
    localparam logic [63:0] TAYLOR_RECIP_3 = ((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42;
    localparam logic [63:0] TAYLOR_RECIP_4 = ((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72;
    localparam logic [63:0] TAYLOR_RECIP_5 = ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110;
    localparam logic [63:0] TAYLOR_RECIP_6 = ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156;
    localparam logic [63:0] TAYLOR_RECIP_7 = ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_DISTANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_FIN   = 3'd5;

    typedef logic signed [TRIG_W-1:0]  t_trig;
    typedef t_trig [NUM_ANGLES-1:0]    t_sine_rom;
    typedef logic [ANGLE_W-1:0]        t_angle;
    typedef logic signed [EXACT_W-1:0] t_exact;
    typedef logic signed [OUT_W-1:0]   t_coord;

    typedef struct packed {
        logic start;
        logic neg;
    } t_div_ctrl;

    typedef struct packed {
        logic   done;
        t_angle qmod;
    } t_div_stat;

    // integer taylor series per degree of the first quadrant, mirrored
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom         tbl;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        logic [63:0]       recip;
        logic [127:0]      wide;
        longint            sum;
        longint            v;
        longint            top;
        tbl = '0;
        top = (64'sd1 <<< TRIG_FRAC_BITS) - 64'sd1;
        for (int a = 0; a <= QUARTER_TURN; a++) begin
            x    = longint'(a) * RAD_PER_DEG_Q30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                case (k)
                    1:       recip = TAYLOR_RECIP_1;
                    2:       recip = TAYLOR_RECIP_2;
                    3:       recip = TAYLOR_RECIP_3;
                    4:       recip = TAYLOR_RECIP_4;
                    5:       recip = TAYLOR_RECIP_5;
                    6:       recip = TAYLOR_RECIP_6;
                    default: recip = TAYLOR_RECIP_7;
                endcase
                wide = 128'((term * x2) >> 30) * 128'(recip);
                term = 64'(wide >> RECIP_SHIFT);
                if ((k % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
            if (v > top) begin
                v = top;
            end
            tbl[a]             = v[TRIG_W-1:0];
            tbl[HALF_TURN - a] = v[TRIG_W-1:0];
            if (a != 0) begin
                tbl[NUM_ANGLES - a] = t_trig'(-v);
                tbl[HALF_TURN + a]  = t_trig'(-v);
            end
        end
        tbl[HALF_TURN] = '0;
        return tbl;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/hsg_step_if.sv
// ----------------------------------------------------------------------------
// hsg_step_if: step request channel
// Valid/ready channel carrying one pen step request with its restart flag.
// ----------------------------------------------------------------------------
interface hsg_step_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

FILE: rtl/hsg_seg_if.sv
// ----------------------------------------------------------------------------
// hsg_seg_if: line segment channel
// Valid/ready channel carrying one segment with draw and curve-end flags.
// ----------------------------------------------------------------------------
interface hsg_seg_if import hsg_pkg::*;;
    logic   valid;
    logic   ready;
    t_coord start_x;
    t_coord start_y;
    t_coord end_x;
    t_coord end_y;
    logic   draw_line;
    logic   curve_done;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, output draw_line, output curve_done, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, input draw_line, input curve_done, output ready);
endinterface

FILE: rtl/hsg_sine_rom.sv
// ----------------------------------------------------------------------------
// hsg_sine_rom: whole-degree sine table
// 360-entry Q1.15 sine ROM with a registered read port.
// ----------------------------------------------------------------------------
module hsg_sine_rom import hsg_pkg::*; (
    input  logic   i_clk,
    input  t_angle i_addr,
    output t_trig  o_data
);

    localparam t_sine_rom ROM = SINE_ROM;

    t_trig r_data;

    always_ff @(posedge i_clk) begin
        if (i_addr < ANGLE_W'(NUM_ANGLES)) begin
            r_data <= ROM[i_addr];
        end else begin
            r_data <= '0;
        end
    end

    assign o_data = r_data;

endmodule

FILE: rtl/hsg_div_mod.sv
// ----------------------------------------------------------------------------
// hsg_div_mod: bit-serial divider with quotient modulo 360
// Restoring division of an unsigned dividend by an unsigned divisor, one
// quotient bit per cycle. Only the quotient modulo 360 is kept, with the
// sign of a truncating signed division applied at the end.
// ----------------------------------------------------------------------------
module hsg_div_mod import hsg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctrl         i_ctrl,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output t_div_stat         o_stat
);

    logic [PROD_W-1:0]    r_num;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_div;
    t_angle               r_qm;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;

    logic [DIV_W:0]       w_shift;
    logic                 w_ge;
    logic [DIV_W:0]       w_rem;
    logic [ANGLE_W:0]     w_qm2;
    t_angle               w_qm;

    always_comb begin
        w_shift = {r_rem, r_num[PROD_W-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_rem   = w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
        // quotient doubles and takes the new bit, kept below 360
        w_qm2   = {r_qm, 1'b0} + {{ANGLE_W{1'b0}}, w_ge};
        if (w_qm2 >= (ANGLE_W + 1)'(NUM_ANGLES)) begin
            w_qm = ANGLE_W'(w_qm2 - (ANGLE_W + 1)'(NUM_ANGLES));
        end else begin
            w_qm = w_qm2[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_neg  <= i_ctrl.neg;
                r_rem  <= '0;
                r_qm   <= '0;
                r_cnt  <= DIV_CNT_W'(PROD_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[PROD_W-2:0], 1'b0};
                r_rem <= w_rem[DIV_W-1:0];
                r_qm  <= w_qm;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.qmod = (r_neg && (r_qm != '0)) ? (ANGLE_W'(NUM_ANGLES) - r_qm) : r_qm;

endmodule

FILE: rtl/hypotrochoid_segment_generator_unit.sv
// ----------------------------------------------------------------------------
// hypotrochoid_segment_generator_unit: spirograph pen stepper
// Each step request advances the pen by one degree and returns one segment
// from the previous pen point to the new one.
// ----------------------------------------------------------------------------
// A step transaction runs from acceptance to the segment appearing at the
// output register in this order: the rim-times-angle product, divider set-up,
// the bit-serial divider that forms the rolling-disk angle (43 quotient bits,
// one per cycle, plus its finish; skipped when the inner radius is zero),
// phases in which a single sine ROM port and a single multiplier accumulate
// the four trig terms, and a final step that truncates and emits once the
// output register is free. A new step is taken only when the unit is idle; a
// finished segment waits in the output register while the next step is already being computed.
// Configuration registers may be written only while no step is in flight.
// ----------------------------------------------------------------------------
module hypotrochoid_segment_generator_unit import hsg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hsg_step_if.sink              i_step,
    hsg_seg_if.source             o_seg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_TRIG,
        S_FIN
    } t_state;

    localparam logic [2:0] PH_LAST = 3'd4;

    // configuration
    logic [CX_W-1:0]         r_centre_x;
    logic [CX_W-1:0]         r_centre_y;
    logic [R_W-1:0]          r_outer;
    logic signed [RIN_W-1:0] r_inner;
    logic [D_W-1:0]          r_pen;
    logic                    r_always;

    // step state
    t_state                  r_state;
    logic [STEP_W-1:0]       r_angle;
    t_angle                  r_amod;
    t_coord                  r_last_x;
    t_coord                  r_last_y;
    t_exact                  r_first_x;
    t_exact                  r_first_y;

    // per-transaction work registers
    logic                    r_first;
    logic signed [RR_W-1:0]  r_rr;
    logic [PROD_W-1:0]       r_prod;
    t_angle                  r_qmod;
    logic [2:0]              r_phase;
    t_exact                  r_ex;
    t_exact                  r_ey;

    // output register
    logic                    r_out_valid;
    t_coord                  r_start_x;
    t_coord                  r_start_y;
    t_coord                  r_end_x;
    t_coord                  r_end_y;
    logic                    r_draw;
    logic                    r_done;

    logic                    w_step_take;
    logic [STEP_W-1:0]       w_angle_eff;
    logic [PROD_W-1:0]       w_prod;
    logic [PROD_W-1:0]       w_dividend;
    logic [DIV_W-1:0]        w_inner_mag;
    t_div_ctrl               w_div_ctrl;
    t_div_stat               w_div_stat;
    t_angle                  w_rom_addr;
    t_trig                   w_rom_data;
    logic signed [RR_W-1:0]  w_mul_a;
    logic signed [RR_W+TRIG_W-1:0] w_mac_prod;
    t_exact                  w_mac;
    logic signed [RR_W+1:0]  w_home_sum;
    t_coord                  w_home_x;
    t_coord                  w_end_x;
    t_coord                  w_end_y;
    logic                    w_curve_done;
    logic                    w_out_free;
    logic [STEP_W-1:0]       w_angle_inc;
    t_angle                  w_amod_inc;

    function automatic t_angle cos_index(input t_angle a);
        logic [ANGLE_W:0] s;
        s = {1'b0, a} + (ANGLE_W + 1)'(QUARTER_TURN);
        if (s >= (ANGLE_W + 1)'(NUM_ANGLES)) begin
            s = s - (ANGLE_W + 1)'(NUM_ANGLES);
        end
        return s[ANGLE_W-1:0];
    endfunction

    // truncation toward zero, then saturation to the coordinate range
    function automatic t_coord trunc_coord(input t_exact v);
        logic                              neg;
        logic [EXACT_W-1:0]                mag;
        logic [EXACT_W-TRIG_FRAC_BITS-1:0] tm;
        t_coord                            res;
        neg = v[EXACT_W-1];
        mag = neg ? unsigned'(-v) : unsigned'(v);
        tm  = mag[EXACT_W-1:TRIG_FRAC_BITS];
        if (!neg) begin
            if (tm > (EXACT_W - TRIG_FRAC_BITS)'((1 << (COORD_BITS - 1)) - 1)) begin
                res = t_coord'((1 << (COORD_BITS - 1)) - 1);
            end else begin
                res = t_coord'(tm[OUT_W-1:0]);
            end
        end else begin
            if (tm > (EXACT_W - TRIG_FRAC_BITS)'(1 << (COORD_BITS - 1))) begin
                res = t_coord'(-(1 << (COORD_BITS - 1)));
            end else begin
                res = t_coord'(0) - t_coord'(tm[OUT_W-1:0]);
            end
        end
        return res;
    endfunction

    hsg_div_mod u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_dividend),
        .i_divisor  (w_inner_mag),
        .o_stat     (w_div_stat)
    );

    hsg_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    assign i_step.ready = (r_state == S_IDLE);
    assign w_step_take  = i_step.valid && (r_state == S_IDLE);
    assign w_angle_eff  = i_step.restart ? STEP_W'(1) : r_angle;

    assign w_prod = PROD_W'(r_outer) * PROD_W'(r_angle);

    always_comb begin
        // numerator is R*t - 1, which is -1 only when the product is zero
        w_dividend      = (r_prod == '0) ? PROD_W'(1) : (r_prod - PROD_W'(1));
        w_inner_mag     = r_inner[RIN_W-1] ? DIV_W'(-r_inner) : DIV_W'(r_inner);
        w_div_ctrl.start = (r_state == S_PREP) && (r_inner != '0);
        w_div_ctrl.neg   = (r_prod == '0) ^ r_inner[RIN_W-1];
    end

    always_comb begin
        case (r_phase)
            3'd0:    w_rom_addr = cos_index(r_amod);
            3'd1:    w_rom_addr = r_amod;
            3'd2:    w_rom_addr = cos_index(r_qmod);
            3'd3:    w_rom_addr = r_qmod;
            default: w_rom_addr = r_amod;
        endcase
    end

    // shared multiplier: disk offset terms first, then pen terms
    assign w_mul_a    = ((r_phase == 3'd1) || (r_phase == 3'd2)) ? r_rr
                                                                  : $signed({3'b000, r_pen});
    assign w_mac_prod = w_mul_a * w_rom_data;
    assign w_mac      = EXACT_W'(w_mac_prod);

    always_comb begin
        w_home_sum = $signed({3'b000, r_centre_x}) + (RR_W + 2)'(r_rr)
                   + $signed({5'b00000, r_pen});
        if (w_home_sum > (RR_W + 2)'((1 << (COORD_BITS - 1)) - 1)) begin
            w_home_x = t_coord'((1 << (COORD_BITS - 1)) - 1);
        end else if (w_home_sum < (RR_W + 2)'(-(1 << (COORD_BITS - 1)))) begin
            w_home_x = t_coord'(-(1 << (COORD_BITS - 1)));
        end else begin
            w_home_x = w_home_sum[OUT_W-1:0];
        end
        w_end_x = trunc_coord(r_ex);
        w_end_y = trunc_coord(r_ey);
        w_curve_done = (!r_first && (r_ex == r_first_x) && (r_ey == r_first_y))
                    || (!r_always && (r_angle > STEP_W'(STEP_LIMIT)));
        w_out_free  = !r_out_valid || o_seg.ready;
        w_angle_inc = r_angle + STEP_W'(1);
        if (w_angle_inc == '0) begin
            w_amod_inc = '0;
        end else if (r_amod == ANGLE_W'(NUM_ANGLES - 1)) begin
            w_amod_inc = '0;
        end else begin
            w_amod_inc = r_amod + ANGLE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x <= CX_W'(512);
            r_centre_y <= CX_W'(384);
            r_outer    <= R_W'(384);
            r_inner    <= RIN_W'(133);
            r_pen      <= D_W'(200);
            r_always   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTRE_X:     r_centre_x <= i_cfg_data[CX_W-1:0];
                CFG_CENTRE_Y:     r_centre_y <= i_cfg_data[CX_W-1:0];
                CFG_OUTER_RADIUS: r_outer    <= i_cfg_data[R_W-1:0];
                CFG_INNER_RADIUS: r_inner    <= $signed(i_cfg_data[RIN_W-1:0]);
                CFG_PEN_DISTANCE: r_pen      <= i_cfg_data[D_W-1:0];
                CFG_ALWAYS_FIN:   r_always   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_angle     <= STEP_W'(1);
            r_amod      <= ANGLE_W'(1);
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a segment emitted in the same cycle refills the register below
            if (r_out_valid && o_seg.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_step_take) begin
                        r_angle <= w_angle_eff;
                        if (i_step.restart) begin
                            r_amod <= ANGLE_W'(1);
                        end
                        r_first <= (w_angle_eff == STEP_W'(1));
                        r_rr    <= $signed({2'b00, r_outer}) - RR_W'(r_inner);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_ex    <= EXACT_W'({r_centre_x, {TRIG_FRAC_BITS{1'b0}}});
                    r_ey    <= EXACT_W'({r_centre_y, {TRIG_FRAC_BITS{1'b0}}});
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_phase <= '0;
                    if (r_inner == '0) begin
                        r_qmod  <= '0;
                        r_state <= S_TRIG;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        r_qmod  <= w_div_stat.qmod;
                        r_state <= S_TRIG;
                    end
                end
                S_TRIG: begin
                    r_phase <= r_phase + 3'd1;
                    case (r_phase)
                        3'd1:    r_ex <= r_ex + w_mac;
                        3'd2:    r_ey <= r_ey + w_mac;
                        3'd3:    r_ex <= r_ex + w_mac;
                        3'd4:    r_ey <= r_ey + w_mac;
                        default: ;
                    endcase
                    if (r_phase == PH_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_start_x   <= r_first ? w_home_x : r_last_x;
                        r_start_y   <= r_first ? t_coord'({2'b00, r_centre_y}) : r_last_y;
                        r_end_x     <= w_end_x;
                        r_end_y     <= w_end_y;
                        r_draw      <= !r_first;
                        r_done      <= w_curve_done;
                        r_last_x    <= w_end_x;
                        r_last_y    <= w_end_y;
                        if (w_curve_done) begin
                            r_first_x <= '0;
                            r_first_y <= '0;
                            r_angle   <= STEP_W'(1);
                            r_amod    <= ANGLE_W'(1);
                        end else begin
                            if (r_first) begin
                                r_first_x <= r_ex;
                                r_first_y <= r_ey;
                            end
                            r_angle <= w_angle_inc;
                            r_amod  <= w_amod_inc;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_seg.valid      = r_out_valid;
    assign o_seg.start_x    = r_start_x;
    assign o_seg.start_y    = r_start_y;
    assign o_seg.end_x      = r_end_x;
    assign o_seg.end_y      = r_end_y;
    assign o_seg.draw_line  = r_draw;
    assign o_seg.curve_done = r_done;

endmodule
